@@ src/sit_pkg.sv @@
// Shared types and codes for the sorted interval table.
package sit_pkg;

   // request kinds
   typedef enum logic [1:0] {
      ACT_ADD      = 2'd0,
      ACT_REMOVE   = 2'd1,
      ACT_SET_TYPE = 2'd2,
      ACT_FIND     = 2'd3
   } action_type;

   // result codes
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_OVERLAP   = 3'd1,
      ST_BAD_INDEX = 3'd2,
      ST_FULL      = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   // one stored interval
   typedef struct packed {
      logic [2:0]  phrase_type;
      logic [30:0] end_frame;
      logic [30:0] start_frame;
   } entry_type;

   // one request as decoded from the stream
   typedef struct packed {
      action_type  action;
      logic [30:0] start_frame;
      logic [30:0] end_frame;
      logic [2:0]  phrase_type;
      logic [5:0]  entry_index;
      logic [30:0] query_position;
   } req_type;

   // one result
   typedef struct packed {
      status_type  status;
      logic [5:0]  hit_index;
      logic [2:0]  hit_type;
      logic [30:0] hit_start;
      logic [30:0] hit_end;
      logic [6:0]  entry_count;
   } rsp_type;

endpackage

@@ src/sit_mem.sv @@
// Entry storage: one write port, one registered read port.
module sit_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output sit_pkg::entry_type  rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  sit_pkg::entry_type  wr_data
);

   sit_pkg::entry_type mem [DEPTH];
   sit_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/sit_ctrl.sv @@
// Sequencer: scans, shifts and rewrites table entries through the memory.
module sit_ctrl #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  sit_pkg::req_type            req,
   output logic                        res_valid,
   input  logic                        res_ready,
   output sit_pkg::rsp_type            res,
   output logic                        mem_rd_en,
   output logic [$clog2(MAX_ENTRIES)-1:0] mem_rd_addr,
   input  sit_pkg::entry_type          mem_rd_data,
   output logic                        mem_wr_en,
   output logic [$clog2(MAX_ENTRIES)-1:0] mem_wr_addr,
   output sit_pkg::entry_type          mem_wr_data
);

   localparam int IW   = $clog2(MAX_ENTRIES);
   localparam int CW   = $clog2(MAX_ENTRIES + 1);
   localparam int CMPW = (CW > 6) ? CW : 6;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DECODE   = 7'b0000010,
      S_SCAN     = 7'b0000100,
      S_SHIFT_UP = 7'b0001000,
      S_SHIFT_DN = 7'b0010000,
      S_RMW      = 7'b0100000,
      S_RESULT   = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   sit_pkg::req_type   req_ff, req_in;
   sit_pkg::rsp_type   res_ff, res_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      scan_ptr_ff, scan_ptr_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [CW-1:0]      chk_idx_ff, chk_idx_in;
   logic [CW-1:0]      place_ff, place_in;
   logic               place_hit_ff, place_hit_in;
   logic [CW-1:0]      sh_ptr_ff, sh_ptr_in;
   logic               pend_ff, pend_in;
   logic [IW-1:0]      pend_addr_ff, pend_addr_in;

   logic [CW-1:0]      sh_prev;
   logic [CW-1:0]      req_idx_c;
   logic               bad_idx;
   logic               full;
   logic               overlap;
   logic               found;
   sit_pkg::entry_type new_entry;

   // build one result word
   function automatic sit_pkg::rsp_type mk_rsp(input sit_pkg::status_type st,
                                               input logic [CW-1:0] idx,
                                               input sit_pkg::entry_type ent,
                                               input logic [CW-1:0] cnt);
      sit_pkg::rsp_type r;
      r.status      = st;
      r.hit_index   = 6'(idx);
      r.hit_type    = ent.phrase_type;
      r.hit_start   = ent.start_frame;
      r.hit_end     = ent.end_frame;
      r.entry_count = 7'(cnt);
      return r;
   endfunction

   // per-entry checks on the word coming back from memory
   assign sh_prev   = sh_ptr_ff - CW'(1);
   assign req_idx_c = CW'(req_ff.entry_index);
   assign bad_idx   = CMPW'(req_ff.entry_index) >= CMPW'(count_ff);
   assign full      = count_ff == CW'(MAX_ENTRIES);
   assign overlap   = (req_ff.start_frame < mem_rd_data.end_frame) &&
                      (req_ff.end_frame > mem_rd_data.start_frame);
   assign found     = (req_ff.query_position >= mem_rd_data.start_frame) &&
                      (req_ff.query_position < mem_rd_data.end_frame);

   always_comb begin
      new_entry.phrase_type = req_ff.phrase_type;
      new_entry.end_frame   = req_ff.end_frame;
      new_entry.start_frame = req_ff.start_frame;
   end

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      count_in     = count_ff;
      scan_ptr_in  = scan_ptr_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      place_in     = place_ff;
      place_hit_in = place_hit_ff;
      sh_ptr_in    = sh_ptr_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = pend_addr_ff;
      mem_wr_data  = mem_rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            unique case (req_ff.action)
               sit_pkg::ACT_ADD, sit_pkg::ACT_FIND: begin
                  scan_ptr_in  = '0;
                  place_in     = count_ff;
                  place_hit_in = 1'b0;
                  state_in     = S_SCAN;
               end
               sit_pkg::ACT_REMOVE: begin
                  if (bad_idx) begin
                     res_in   = mk_rsp(sit_pkg::ST_BAD_INDEX, '0, '0, count_ff);
                     state_in = S_RESULT;
                  end else begin
                     sh_ptr_in = req_idx_c + CW'(1);
                     state_in  = S_SHIFT_DN;
                  end
               end
               sit_pkg::ACT_SET_TYPE: begin
                  if (bad_idx) begin
                     res_in   = mk_rsp(sit_pkg::ST_BAD_INDEX, '0, '0, count_ff);
                     state_in = S_RESULT;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = req_idx_c[IW-1:0];
                     state_in    = S_RMW;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end

         // walk entries 0..n-1, one read a cycle, check each word in the cycle after its read
         S_SCAN: begin
            if (chk_vld_ff && req_ff.action == sit_pkg::ACT_ADD && overlap) begin
               res_in   = mk_rsp(sit_pkg::ST_OVERLAP, '0, '0, count_ff);
               state_in = S_RESULT;
            end else if (chk_vld_ff && req_ff.action == sit_pkg::ACT_FIND && found) begin
               res_in   = mk_rsp(sit_pkg::ST_OK, chk_idx_ff, mem_rd_data, count_ff);
               state_in = S_RESULT;
            end else if (!chk_vld_ff && scan_ptr_ff == count_ff) begin
               if (req_ff.action == sit_pkg::ACT_FIND) begin
                  res_in   = mk_rsp(sit_pkg::ST_NOT_FOUND, '0, '0, count_ff);
                  state_in = S_RESULT;
               end else if (full) begin
                  res_in   = mk_rsp(sit_pkg::ST_FULL, '0, '0, count_ff);
                  state_in = S_RESULT;
               end else begin
                  sh_ptr_in = count_ff;
                  state_in  = S_SHIFT_UP;
               end
            end else begin
               // insert place: first entry with a larger start
               if (chk_vld_ff && !place_hit_ff &&
                   mem_rd_data.start_frame > req_ff.start_frame) begin
                  place_in     = chk_idx_ff;
                  place_hit_in = 1'b1;
               end
               if (scan_ptr_ff != count_ff) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = scan_ptr_ff[IW-1:0];
                  scan_ptr_in = scan_ptr_ff + CW'(1);
                  chk_vld_in  = 1'b1;
                  chk_idx_in  = scan_ptr_ff;
               end
            end
         end

         // move entries place..n-1 up by one, top first, then write the new one
         S_SHIFT_UP: begin
            if (pend_ff) begin
               mem_wr_en = 1'b1;
            end
            if (sh_ptr_ff != place_ff) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = sh_prev[IW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = sh_ptr_ff[IW-1:0];
               sh_ptr_in    = sh_prev;
            end else if (!pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = place_ff[IW-1:0];
               mem_wr_data = new_entry;
               count_in    = CW'(count_ff + CW'(1));
               res_in      = mk_rsp(sit_pkg::ST_OK, place_ff, '0, count_in);
               state_in    = S_RESULT;
            end
         end

         // move entries idx+1..n-1 down by one
         S_SHIFT_DN: begin
            if (pend_ff) begin
               mem_wr_en = 1'b1;
            end
            if (sh_ptr_ff < count_ff) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = sh_ptr_ff[IW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = sh_prev[IW-1:0];
               sh_ptr_in    = sh_ptr_ff + CW'(1);
            end else if (!pend_ff) begin
               count_in = CW'(count_ff - CW'(1));
               res_in   = mk_rsp(sit_pkg::ST_OK, req_idx_c, '0, count_in);
               state_in = S_RESULT;
            end
         end

         // type update on the entry read in decode
         S_RMW: begin
            mem_wr_en               = 1'b1;
            mem_wr_addr             = req_idx_c[IW-1:0];
            mem_wr_data.phrase_type = req_ff.phrase_type;
            res_in   = mk_rsp(sit_pkg::ST_OK, req_idx_c, '0, count_ff);
            state_in = S_RESULT;
         end

         S_RESULT: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         chk_vld_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         chk_vld_ff <= chk_vld_in;
         pend_ff    <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      res_ff       <= res_in;
      scan_ptr_ff  <= scan_ptr_in;
      chk_idx_ff   <= chk_idx_in;
      place_ff     <= place_in;
      place_hit_ff <= place_hit_in;
      sh_ptr_ff    <= sh_ptr_in;
      pend_addr_ff <= pend_addr_in;
   end

   assign req_ready = state_ff == S_IDLE;
   assign res_valid = state_ff == S_RESULT;
   assign res       = res_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count above table size");

   a_no_rw_same_addr: assert property (@(posedge clock) disable iff (reset)
      (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
      else $error("read and write of the same entry in one cycle");

   a_count_moves_at_result: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |-> (state_ff == S_RESULT))
      else $error("entry count changed outside result handoff");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(state_ff == S_RESULT) &&
       req_ff.action == sit_pkg::ACT_ADD && res_ff.status == sit_pkg::ST_OK)
      |-> (count_ff == CW'($past(count_ff) + CW'(1))))
      else $error("successful add did not grow the table by one");
`endif

endmodule

@@ src/sorted_interval_table_core.sv @@
// Sorted interval table: top level with stream ports and result register.
// Requests are handled one at a time, limited by the one-read, one-write entry
// memory; the next request can be taken in the cycle after the result leaves
// the sequencer.
// Reset: synchronous; clears entry count and control state, table empty at once, no clearing pass.
module sorted_interval_table_core #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_frame[30:0], end_frame[61:31], phrase_type[64:62],
   // entry_index[70:65], query_position[101:71], zero pad[103:102]
   input  logic [103:0] req_tdata,
   // action[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit_index[5:0], hit_type[8:6], hit_start[39:9], hit_end[70:40],
   // entry_count[77:71], zero pad[79:78]
   output logic [79:0]  rsp_tdata,
   // status[2:0]
   output logic [2:0]   rsp_tuser
);

   localparam int IW = $clog2(MAX_ENTRIES);

   sit_pkg::req_type   req;
   sit_pkg::rsp_type   res;
   logic               res_valid;
   logic               res_ready;
   logic               mem_rd_en;
   logic [IW-1:0]      mem_rd_addr;
   sit_pkg::entry_type mem_rd_data;
   logic               mem_wr_en;
   logic [IW-1:0]      mem_wr_addr;
   sit_pkg::entry_type mem_wr_data;
   logic               out_valid_ff, out_valid_in;
   sit_pkg::rsp_type   out_data_ff;

   // request unpack
   always_comb begin
      req.action         = sit_pkg::action_type'(req_tuser);
      req.start_frame    = req_tdata[30:0];
      req.end_frame      = req_tdata[61:31];
      req.phrase_type    = req_tdata[64:62];
      req.entry_index    = req_tdata[70:65];
      req.query_position = req_tdata[101:71];
   end

   sit_ctrl #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req         (req),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   sit_mem #(
      .DEPTH(MAX_ENTRIES),
      .AW   (IW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // result register: frees the sequencer while a result waits downstream
   assign res_ready    = !out_valid_ff || rsp_tready;
   assign out_valid_in = res_ready ? res_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         out_data_ff <= res;
      end
   end

   // result pack
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_data_ff.status;
   assign rsp_tdata  = {2'b00, out_data_ff.entry_count, out_data_ff.hit_end,
                        out_data_ff.hit_start, out_data_ff.hit_type,
                        out_data_ff.hit_index};

endmodule

@@ sim/interval_table_checker.sv @@
`timescale 1ns / 100ps
// Checker for the sorted interval table: tracks table contents, predicts and compares results.
module interval_table_checker #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // start_frame[30:0], end_frame[61:31], phrase_type[64:62],
   // entry_index[70:65], query_position[101:71], zero pad[103:102]
   input  logic [103:0] req_tdata,
   // action[1:0]
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit_index[5:0], hit_type[8:6], hit_start[39:9], hit_end[70:40],
   // entry_count[77:71], zero pad[79:78]
   input  logic [79:0]  rsp_tdata,
   // status[2:0]
   input  logic [2:0]   rsp_tuser,
   output int           fault_count,
   output int           outstanding,
   output int           table_fill,
   output int           taken_count,
   output int           checked_count,
   output int           peak_fill,
   output int           overlap_seen,
   output int           full_seen,
   output int           bad_index_seen,
   output int           miss_seen
);

   // shadow copy of the table, kept in sorted order
   logic [30:0] span_start [TABLE_DEPTH];
   logic [30:0] span_end   [TABLE_DEPTH];
   logic [2:0]  span_kind  [TABLE_DEPTH];
   int          span_count = 0;

   // results predicted but not yet returned, oldest first
   sit_pkg::rsp_type awaited_results [$];

   int          faults = 0;
   int          taken = 0;
   int          checked = 0;
   int          peak = 0;
   int          overlaps = 0;
   int          fulls = 0;
   int          bad_indexes = 0;
   int          misses = 0;
   sit_pkg::req_type incoming;
   sit_pkg::rsp_type predicted;
   sit_pkg::rsp_type observed;

   // apply one request to the shadow table and work out its result
   task automatic table_apply(input sit_pkg::req_type rq, output sit_pkg::rsp_type rs);
      int i;
      int slot;
      int found;
      bit clash;
      rs = '0;
      rs.status = sit_pkg::ST_OK;
      case (rq.action)
         sit_pkg::ACT_ADD: begin
            // half-open overlap test, taken literally even for empty or reversed spans
            clash = 1'b0;
            for (i = 0; i < span_count; i++) begin
               if (rq.start_frame < span_end[i] && rq.end_frame > span_start[i])
                  clash = 1'b1;
            end
            if (clash) begin
               rs.status = sit_pkg::ST_OVERLAP;
            end else if (span_count >= TABLE_DEPTH) begin
               rs.status = sit_pkg::ST_FULL;
            end else begin
               // new entry goes after every entry with start <= its own
               slot = 0;
               while (slot < span_count && span_start[slot] <= rq.start_frame)
                  slot++;
               for (i = span_count; i > slot; i--) begin
                  span_start[i] = span_start[i - 1];
                  span_end[i]   = span_end[i - 1];
                  span_kind[i]  = span_kind[i - 1];
               end
               span_start[slot] = rq.start_frame;
               span_end[slot]   = rq.end_frame;
               span_kind[slot]  = rq.phrase_type;
               span_count++;
               rs.hit_index = 6'(slot);
            end
         end
         sit_pkg::ACT_REMOVE: begin
            if (int'(rq.entry_index) >= span_count) begin
               rs.status = sit_pkg::ST_BAD_INDEX;
            end else begin
               for (i = int'(rq.entry_index); i + 1 < span_count; i++) begin
                  span_start[i] = span_start[i + 1];
                  span_end[i]   = span_end[i + 1];
                  span_kind[i]  = span_kind[i + 1];
               end
               span_count--;
               rs.hit_index = rq.entry_index;
            end
         end
         sit_pkg::ACT_SET_TYPE: begin
            if (int'(rq.entry_index) >= span_count) begin
               rs.status = sit_pkg::ST_BAD_INDEX;
            end else begin
               span_kind[rq.entry_index] = rq.phrase_type;
               rs.hit_index = rq.entry_index;
            end
         end
         default: begin
            // first entry in sorted order whose span holds the position
            found = -1;
            for (i = 0; i < span_count; i++) begin
               if (found < 0 && rq.query_position >= span_start[i] &&
                   rq.query_position < span_end[i])
                  found = i;
            end
            if (found < 0) begin
               rs.status = sit_pkg::ST_NOT_FOUND;
            end else begin
               rs.hit_index = 6'(found);
               rs.hit_type  = span_kind[found];
               rs.hit_start = span_start[found];
               rs.hit_end   = span_end[found];
            end
         end
      endcase
      rs.entry_count = 7'(span_count);
   endtask

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] seen);
      if (seen !== want) begin
         if (faults < 10)
            $display("%t: %s mismatch on result %0d: expected %0h, got %0h",
                     $time, label, checked, want, seen);
         faults++;
      end
   endtask

   // watch both channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         span_count = 0;
         awaited_results.delete();
      end else begin
         // accepted request: predict and queue its result
         if (req_tvalid && req_tready) begin
            incoming.action         = sit_pkg::action_type'(req_tuser);
            incoming.start_frame    = req_tdata[30:0];
            incoming.end_frame      = req_tdata[61:31];
            incoming.phrase_type    = req_tdata[64:62];
            incoming.entry_index    = req_tdata[70:65];
            incoming.query_position = req_tdata[101:71];
            table_apply(incoming, predicted);
            awaited_results.push_back(predicted);
            taken++;
            if (span_count > peak)
               peak = span_count;
            case (predicted.status)
               sit_pkg::ST_OVERLAP:   overlaps++;
               sit_pkg::ST_FULL:      fulls++;
               sit_pkg::ST_BAD_INDEX: bad_indexes++;
               sit_pkg::ST_NOT_FOUND: misses++;
               default: ;
            endcase
         end
         // accepted result: compare with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            observed.status      = sit_pkg::status_type'(rsp_tuser);
            observed.hit_index   = rsp_tdata[5:0];
            observed.hit_type    = rsp_tdata[8:6];
            observed.hit_start   = rsp_tdata[39:9];
            observed.hit_end     = rsp_tdata[70:40];
            observed.entry_count = rsp_tdata[77:71];
            if (awaited_results.size() == 0) begin
               if (faults < 10)
                  $display("%t: result %0d arrived with none outstanding", $time, checked);
               faults++;
            end else begin
               predicted = awaited_results.pop_front();
               check_field("status", 32'(predicted.status), 32'(rsp_tuser));
               check_field("hit_index", 32'(predicted.hit_index), 32'(observed.hit_index));
               check_field("hit_type", 32'(predicted.hit_type), 32'(observed.hit_type));
               check_field("hit_start", 32'(predicted.hit_start), 32'(observed.hit_start));
               check_field("hit_end", 32'(predicted.hit_end), 32'(observed.hit_end));
               check_field("entry_count", 32'(predicted.entry_count),
                           32'(observed.entry_count));
            end
            checked++;
         end
      end
      fault_count    <= faults;
      outstanding    <= awaited_results.size();
      table_fill     <= span_count;
      taken_count    <= taken;
      checked_count  <= checked;
      peak_fill      <= peak;
      overlap_seen   <= overlaps;
      full_seen      <= fulls;
      bad_index_seen <= bad_indexes;
      miss_seen      <= misses;
   end

endmodule

@@ sim/sorted_interval_table_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the sorted interval table: stimulus, back-pressure and verdict.
module sorted_interval_table_core_tb;

   localparam int          TABLE_DEPTH   = 64;
   localparam int          RANDOM_BLOCKS = 10;
   localparam int          BLOCK_ITEMS   = 175;
   localparam int          SETTLE_CYCLES = 2 * TABLE_DEPTH + 12;
   localparam logic [30:0] FRAME_MAX     = 31'h7FFF_FFFF;
   localparam logic [30:0] HIGH_WINDOW   = 31'h7FFF_E000;

   typedef enum int {
      MIX_FILL,
      MIX_BALANCED,
      MIX_DRAIN
   } mix_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;

   int           idle_pct = 0;
   int           stall_pct = 0;
   logic [30:0]  window_base = '0;

   int           fault_count;
   int           outstanding;
   int           table_fill;
   int           taken_count;
   int           checked_count;
   int           peak_fill;
   int           overlap_seen;
   int           full_seen;
   int           bad_index_seen;
   int           miss_seen;

   sorted_interval_table_core #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   interval_table_checker #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .fault_count    (fault_count),
      .outstanding    (outstanding),
      .table_fill     (table_fill),
      .taken_count    (taken_count),
      .checked_count  (checked_count),
      .peak_fill      (peak_fill),
      .overlap_seen   (overlap_seen),
      .full_seen      (full_seen),
      .bad_index_seen (bad_index_seen),
      .miss_seen      (miss_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // random back-pressure on the result channel
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // present one request, with random idle cycles ahead of it, and wait for acceptance
   task automatic send_request(input sit_pkg::action_type act, input logic [30:0] s,
                               input logic [30:0] e, input logic [2:0] kind,
                               input logic [5:0] idx, input logic [30:0] pos);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, pos, idx, kind, e, s};
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off until every outstanding result has come back
   task automatic wait_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // one random request; content mostly lands in the current frame window
   task automatic random_request(input mix_type mix);
      int                 roll;
      int                 cap;
      int                 add_cut;
      int                 remove_cut;
      int                 find_cut;
      sit_pkg::action_type act;
      logic [30:0]        s;
      logic [30:0]        e;
      logic [30:0]        pos;
      logic [5:0]         idx;
      logic [2:0]         kind;
      case (mix)
         MIX_FILL: begin
            add_cut = 70; remove_cut = 77; find_cut = 92;
         end
         MIX_DRAIN: begin
            add_cut = 15; remove_cut = 70; find_cut = 88;
         end
         default: begin
            add_cut = 38; remove_cut = 62; find_cut = 85;
         end
      endcase
      s    = window_base + 31'($urandom_range(0, 4095));
      e    = s + 31'($urandom_range(1, 8));
      pos  = window_base + 31'($urandom_range(0, 4103));
      kind = 3'($urandom_range(0, 7));
      cap  = (table_fill > 63) ? 63 : table_fill;
      if ($urandom_range(0, 99) < 85)
         idx = 6'($urandom_range(0, cap));
      else
         idx = 6'($urandom_range(0, 63));
      // empty and reversed spans now and then
      roll = $urandom_range(0, 99);
      if (roll < 5)
         e = s;
      else if (roll < 10)
         e = s - 31'($urandom_range(1, 64));
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 6) begin
         // noise: every field over its full range
         act = sit_pkg::action_type'($urandom_range(0, 3));
         s   = 31'($urandom);
         e   = 31'($urandom);
         pos = 31'($urandom);
         idx = 6'($urandom);
      end else if (roll < add_cut) begin
         act = sit_pkg::ACT_ADD;
      end else if (roll < remove_cut) begin
         act = sit_pkg::ACT_REMOVE;
      end else if (roll < find_cut) begin
         act = sit_pkg::ACT_FIND;
      end else begin
         act = sit_pkg::ACT_SET_TYPE;
      end
      send_request(act, s, e, kind, idx, pos);
   endtask

   // run limit
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int      blk;
      mix_type mix;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, touching and degenerate spans
      send_request(sit_pkg::ACT_FIND, 31'd0, 31'd0, 3'd0, 6'd0, 31'd0);
      send_request(sit_pkg::ACT_REMOVE, 31'd0, 31'd0, 3'd0, 6'd0, 31'd0);
      send_request(sit_pkg::ACT_SET_TYPE, 31'd0, 31'd0, 3'd7, 6'd63, 31'd0);
      send_request(sit_pkg::ACT_ADD, 31'd0, FRAME_MAX, 3'd7, 6'd0, 31'd0);
      send_request(sit_pkg::ACT_FIND, 31'd0, 31'd0, 3'd0, 6'd0, FRAME_MAX - 31'd1);
      send_request(sit_pkg::ACT_FIND, 31'd0, 31'd0, 3'd0, 6'd0, FRAME_MAX);
      send_request(sit_pkg::ACT_ADD, 31'd5, 31'd10, 3'd1, 6'd0, 31'd0);
      send_request(sit_pkg::ACT_REMOVE, 31'd0, 31'd0, 3'd0, 6'd0, 31'd0);
      send_request(sit_pkg::ACT_ADD, 31'd100, 31'd200, 3'd3, 6'd0, 31'd0);
      send_request(sit_pkg::ACT_ADD, 31'd50, 31'd100, 3'd1, 6'd0, 31'd0);
      send_request(sit_pkg::ACT_ADD, 31'd200, 31'd300, 3'd2, 6'd0, 31'd0);
      // empty span strictly inside an entry is still rejected
      send_request(sit_pkg::ACT_ADD, 31'd150, 31'd150, 3'd0, 6'd0, 31'd0);
      // empty span on a boundary goes in after the equal start
      send_request(sit_pkg::ACT_ADD, 31'd100, 31'd100, 3'd6, 6'd0, 31'd0);
      send_request(sit_pkg::ACT_ADD, 31'd400, 31'd350, 3'd4, 6'd0, 31'd0);
      send_request(sit_pkg::ACT_FIND, 31'd0, 31'd0, 3'd0, 6'd0, 31'd99);
      send_request(sit_pkg::ACT_FIND, 31'd0, 31'd0, 3'd0, 6'd0, 31'd100);
      send_request(sit_pkg::ACT_SET_TYPE, 31'd0, 31'd0, 3'd5, 6'd1, 31'd0);
      send_request(sit_pkg::ACT_FIND, 31'd0, 31'd0, 3'd0, 6'd0, 31'd150);
      send_request(sit_pkg::ACT_SET_TYPE, 31'd0, 31'd0, 3'd2, 6'd5, 31'd0);
      send_request(sit_pkg::ACT_REMOVE, 31'd0, 31'd0, 3'd0, 6'd4, 31'd0);
      send_request(sit_pkg::ACT_FIND, 31'd0, 31'd0, 3'd0, 6'd0, 31'd370);
      send_request(sit_pkg::ACT_REMOVE, 31'd0, 31'd0, 3'd0, 6'd63, 31'd0);
      send_request(sit_pkg::ACT_ADD, FRAME_MAX - 31'd1, FRAME_MAX, 3'd7, 6'd0, 31'd0);
      send_request(sit_pkg::ACT_FIND, 31'd0, 31'd0, 3'd0, 6'd0, FRAME_MAX - 31'd1);
      wait_results();

      // random blocks: fill, mixed and drain traffic under rotating idle and stall profiles
      for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         case (blk % 4)
            0: begin
               idle_pct = 0;  stall_pct <= 0;
            end
            1: begin
               idle_pct = 68; stall_pct <= 0;
            end
            2: begin
               idle_pct = 0;  stall_pct <= 68;
            end
            default: begin
               idle_pct = 37; stall_pct <= 37;
            end
         endcase
         mix = mix_type'(blk % 3);
         case ($urandom_range(0, 2))
            0:       window_base = '0;
            1:       window_base = HIGH_WINDOW;
            default: window_base = 31'($urandom_range(0, 32'h7FF0_0000));
         endcase
         repeat (BLOCK_ITEMS) random_request(mix);
         wait_results();
      end

      // quiet period to catch stray results
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run sent %0d requests and checked %0d results; table peaked at %0d of %0d.",
               taken_count, checked_count, peak_fill, TABLE_DEPTH);
      $display("Rejections: %0d overlap, %0d full, %0d bad index; %0d finds missed.",
               overlap_seen, full_seen, bad_index_seen, miss_seen);
      if (fault_count == 0 && outstanding == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
src/sit_pkg.sv
src/sit_mem.sv
src/sit_ctrl.sv
src/sorted_interval_table_core.sv
sim/interval_table_checker.sv
sim/sorted_interval_table_core_tb.sv
